[hdl/rtq_pkg.sv]
// Shared types, command codes and constants for the retransmit outbox queue.
// No dependencies.
package rtq_pkg;

    localparam int DEF_CAPACITY = 16;

    localparam logic [31:0] ACK_TIMEOUT_RESET = 32'd10000;

    // floor(x / 1000) == (x * DIV1000_MUL) >> DIV1000_SH for every 32-bit x
    localparam logic [28:0] DIV1000_MUL = 29'd274877907;
    localparam int          DIV1000_SH  = 38;
    localparam int          PROD_W      = 61;

    localparam logic [2:0] CMD_ENQ_TEMP    = 3'd0;
    localparam logic [2:0] CMD_ENQ_BUBBLE  = 3'd1;
    localparam logic [2:0] CMD_POLL        = 3'd2;
    localparam logic [2:0] CMD_RECORD_SEND = 3'd3;
    localparam logic [2:0] CMD_LOST        = 3'd4;
    localparam logic [2:0] CMD_ACK         = 3'd5;
    localparam logic [2:0] CMD_COMPARE     = 3'd6;
    localparam logic [2:0] CMD_CLEAR       = 3'd7;

    localparam logic KIND_TEMP   = 1'b0;
    localparam logic KIND_BUBBLE = 1'b1;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [31:0] sequence_req;
        logic        sequence_ok;
        logic [31:0] captured_at_ms;
        logic [31:0] payload_a;
        logic [31:0] payload_b;
        logic [31:0] payload_c;
        logic        payload_flag;
        logic        link_ready;
        logic [31:0] now_ms;
    } t_item;

    typedef struct packed {
        logic        ok;
        logic        is_retry;
        logic [4:0]  entry_count;
        logic [31:0] dropped_count;
        logic        last_dropped_kind;
        logic [31:0] last_dropped_sequence;
        logic        head_kind;
        logic [31:0] head_sequence;
        logic [22:0] head_age_seconds;
        logic [63:0] head_payload_low;
        logic [32:0] head_payload_high;
    } t_result;

    // Classified command handed from the front to the back.
    typedef struct packed {
        logic [2:0]  cmd;
        logic        enq_ok;
        logic        kind;
        logic        flag;
        logic [31:0] seq;
        logic [31:0] cap_t;
        logic [31:0] pa;
        logic [31:0] pb;
        logic [31:0] pc;
        logic        link;
        logic [31:0] now;
    } t_work;

    typedef struct packed {
        logic        kind;
        logic        flag;
        logic [31:0] seq;
        logic [31:0] time_ms;
        logic [63:0] ab;
        logic [31:0] c;
    } t_slot;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

    // IEEE single equality on raw bits: NaN never equal, +0 equals -0.
    function automatic logic fp_eq(input logic [31:0] x, input logic [31:0] y);
        logic x_nan;
        logic y_nan;
        x_nan = (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
        y_nan = (y[30:23] == 8'hFF) && (y[22:0] != 23'd0);
        if (x_nan || y_nan) begin
            return 1'b0;
        end
        if (x[30:0] == 31'd0 && y[30:0] == 31'd0) begin
            return 1'b1;
        end
        return x == y;
    endfunction

endpackage

[hdl/rtq_if.sv]
// Valid/ready channel interfaces for command items and result items.
// Depends on rtq_pkg.
interface rtq_item_if import rtq_pkg::*; ();
    logic  valid;
    logic  ready;
    t_item payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface rtq_result_if import rtq_pkg::*; ();
    logic    valid;
    logic    ready;
    t_result payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[hdl/rtq_fifo.sv]
// Two-entry queue of classified commands between front and back.
// Depends on rtq_pkg.
module rtq_fifo import rtq_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_work   i_wdata,
    input  logic    i_pop,
    output t_work   o_rdata,
    output t_q_stat o_stat
);
    t_work      r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_rdata     = r_mem[r_rp];
    assign o_stat.empty = (r_cnt == 2'd0);
    assign o_stat.full  = (r_cnt == 2'd2);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && !i_pop && r_cnt == 2'd2))
        else $error("queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && r_cnt == 2'd0))
        else $error("queue underflow");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("queue count out of range");
endmodule

[hdl/rtq_front.sv]
// Front end: accepts command items and classifies enqueue commands.
// Depends on rtq_pkg, rtq_if.
module rtq_front import rtq_pkg::*; (
    rtq_item_if.sink i_cmd_ch,
    input  t_q_stat  i_stat,
    output logic     o_push,
    output t_work    o_work
);
    t_item s_it;

    assign s_it           = i_cmd_ch.payload;
    assign i_cmd_ch.ready = !i_stat.full;
    assign o_push         = i_cmd_ch.valid && !i_stat.full;

    always_comb begin
        o_work.cmd   = s_it.cmd;
        o_work.seq   = s_it.sequence_req;
        o_work.cap_t = s_it.captured_at_ms;
        o_work.pa    = s_it.payload_a;
        o_work.pb    = s_it.payload_b;
        o_work.pc    = s_it.payload_c;
        o_work.link  = s_it.link_ready;
        o_work.now   = s_it.now_ms;
        case (s_it.cmd)
            CMD_ENQ_BUBBLE: begin
                // bubble records need pressure samples; stored flag is always set
                o_work.enq_ok = s_it.sequence_ok && s_it.payload_flag;
                o_work.kind   = KIND_BUBBLE;
                o_work.flag   = 1'b1;
            end
            CMD_ENQ_TEMP: begin
                o_work.enq_ok = s_it.sequence_ok;
                o_work.kind   = KIND_TEMP;
                o_work.flag   = s_it.payload_flag;
            end
            default: begin
                o_work.enq_ok = 1'b0;
                o_work.kind   = KIND_TEMP;
                o_work.flag   = 1'b0;
            end
        endcase
    end
endmodule

[hdl/rtq_back.sv]
// Back end: executes queued commands against the slot ring and builds results.
// Depends on rtq_pkg, rtq_if.
module rtq_back import rtq_pkg::*; #(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    input  t_q_stat i_stat,
    input  t_work   i_work,
    output logic    o_pop,
    rtq_result_if.source o_res_ch
);
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int SW    = CNT_W + 1;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EXEC = 3'd1;
    localparam logic [2:0] ST_HEAD = 3'd2;
    localparam logic [2:0] ST_AGE  = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    function automatic logic [IDX_W-1:0] wrap(input logic [SW-1:0] s);
        if (s >= SW'(CAPACITY)) begin
            return IDX_W'(s - SW'(CAPACITY));
        end
        return IDX_W'(s);
    endfunction

    t_slot r_mem [CAPACITY];
    t_slot r_rd_head;
    t_slot r_rd_back;

    logic [2:0]        r_st;
    t_work             r_work;
    logic [31:0]       r_timeout;
    logic [IDX_W-1:0]  r_head, n_head;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [31:0]       r_last, n_last;
    logic [31:0]       r_dtot, n_dtot;
    logic              r_dkind, n_dkind;
    logic [31:0]       r_dseq, n_dseq;
    logic              r_sent, n_sent;
    logic              r_due, n_due;
    logic              r_ok, n_ok;
    logic [PROD_W-1:0] r_prod;
    logic              r_out_valid;
    t_result           r_out;

    logic              s_we;
    logic [IDX_W-1:0]  s_tail;
    logic [IDX_W-1:0]  s_back_idx;
    logic              s_emit;
    logic [31:0]       s_diff;

    assign s_back_idx = (r_count == '0) ? r_head
                      : wrap(SW'(r_head) + SW'(r_count) - SW'(1));

    always_ff @(posedge i_clk) begin
        r_rd_head <= r_mem[r_head];
        r_rd_back <= r_mem[s_back_idx];
        if (s_we) begin
            r_mem[s_tail] <= '{kind: r_work.kind, flag: r_work.flag, seq: r_work.seq,
                               time_ms: r_work.cap_t, ab: {r_work.pb, r_work.pa},
                               c: r_work.pc};
        end
    end

    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        n_last  = r_last;
        n_dtot  = r_dtot;
        n_dkind = r_dkind;
        n_dseq  = r_dseq;
        n_sent  = r_sent;
        n_due   = r_due;
        n_ok    = 1'b0;
        s_we    = 1'b0;
        s_tail  = r_head;
        unique case (r_work.cmd)
            CMD_ENQ_TEMP, CMD_ENQ_BUBBLE: begin
                if (r_work.enq_ok) begin
                    if (r_count == CNT_W'(CAPACITY)) begin
                        // ring full: drop the oldest entry
                        n_dkind = r_rd_head.kind;
                        n_dseq  = r_rd_head.seq;
                        n_dtot  = r_dtot + 32'd1;
                        n_head  = wrap(SW'(r_head) + SW'(1));
                        n_count = r_count - CNT_W'(1);
                        n_sent  = 1'b0;
                        n_due   = (n_count != '0);
                    end
                    s_tail  = wrap(SW'(n_head) + SW'(n_count));
                    s_we    = (r_st == ST_EXEC);
                    n_count = n_count + CNT_W'(1);
                    if (n_count == CNT_W'(1)) begin
                        n_sent = 1'b0;
                        n_due  = 1'b1;
                    end
                    n_ok = 1'b1;
                end
            end
            CMD_POLL: begin
                if (r_count != '0 && r_work.link) begin
                    n_ok = r_due || (r_sent && (r_work.now - r_last) >= r_timeout);
                end
            end
            CMD_RECORD_SEND: begin
                if (r_count != '0) begin
                    n_last = r_work.now;
                    n_sent = 1'b1;
                    n_due  = 1'b0;
                end
            end
            CMD_LOST: begin
                if (r_count != '0 && r_sent) begin
                    n_due = 1'b1;
                end
            end
            CMD_ACK: begin
                if (r_count != '0 && r_rd_head.seq == r_work.seq) begin
                    n_head  = wrap(SW'(r_head) + SW'(1));
                    n_count = r_count - CNT_W'(1);
                    n_sent  = 1'b0;
                    n_due   = (n_count != '0);
                    n_ok    = 1'b1;
                end
            end
            CMD_COMPARE: begin
                if (r_count != '0 && r_rd_back.kind == KIND_TEMP) begin
                    n_ok = fp_eq(r_rd_back.ab[31:0], r_work.pa)
                        && fp_eq(r_rd_back.ab[63:32], r_work.pb);
                end
            end
            CMD_CLEAR: begin
                n_head  = '0;
                n_count = '0;
                n_last  = '0;
                n_dtot  = '0;
                n_dkind = KIND_TEMP;
                n_dseq  = '0;
                n_sent  = 1'b0;
                n_due   = 1'b0;
            end
            default: begin
            end
        endcase
    end

    assign s_diff   = r_work.now - r_rd_head.time_ms;
    assign s_emit   = (r_st == ST_EMIT) && (!r_out_valid || o_res_ch.ready);
    assign o_pop    = (r_st == ST_IDLE) && !i_stat.empty;

    assign o_res_ch.valid   = r_out_valid;
    assign o_res_ch.payload = r_out;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_work <= i_work;
        end
        if (r_st == ST_AGE) begin
            r_prod <= PROD_W'(s_diff) * PROD_W'(DIV1000_MUL);
        end
        if (r_st == ST_EXEC) begin
            r_ok <= n_ok;
        end
        if (s_emit) begin
            r_out.ok                    <= r_ok;
            r_out.is_retry              <= r_sent;
            r_out.entry_count           <= 5'(r_count);
            r_out.dropped_count         <= r_dtot;
            r_out.last_dropped_kind     <= r_dkind;
            r_out.last_dropped_sequence <= r_dseq;
            if (r_count != '0) begin
                r_out.head_kind         <= r_rd_head.kind;
                r_out.head_sequence     <= r_rd_head.seq;
                r_out.head_age_seconds  <= r_prod[PROD_W-1:DIV1000_SH];
                r_out.head_payload_low  <= r_rd_head.ab;
                r_out.head_payload_high <= {r_rd_head.flag, r_rd_head.c};
            end else begin
                r_out.head_kind         <= 1'b0;
                r_out.head_sequence     <= '0;
                r_out.head_age_seconds  <= '0;
                r_out.head_payload_low  <= '0;
                r_out.head_payload_high <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= ST_IDLE;
            r_timeout   <= ACK_TIMEOUT_RESET;
            r_head      <= '0;
            r_count     <= '0;
            r_last      <= '0;
            r_dtot      <= '0;
            r_dkind     <= KIND_TEMP;
            r_dseq      <= '0;
            r_sent      <= 1'b0;
            r_due       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_timeout <= i_cfg_wdata;
            end
            if (s_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_res_ch.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_st)
                ST_IDLE: begin
                    if (!i_stat.empty) begin
                        r_st <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    r_head  <= n_head;
                    r_count <= n_count;
                    r_last  <= n_last;
                    r_dtot  <= n_dtot;
                    r_dkind <= n_dkind;
                    r_dseq  <= n_dseq;
                    r_sent  <= n_sent;
                    r_due   <= n_due;
                    r_st    <= ST_HEAD;
                end
                ST_HEAD: r_st <= ST_AGE;
                ST_AGE:  r_st <= ST_EMIT;
                ST_EMIT: begin
                    if (s_emit) begin
                        r_st <= ST_IDLE;
                    end
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");
    a_head_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_head) < CAPACITY)
        else $error("head index out of range");
    a_enq_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_EXEC && r_work.enq_ok) |=> (r_count != '0))
        else $error("accepted enqueue left ring empty");
    a_pop_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_st == ST_EXEC))
        else $error("popped command not executed");
endmodule

[hdl/retransmit_outbox_queue_core.sv]
// Retransmit outbox queue: ring of CAPACITY records with stop-and-wait resend.
// The back-end sequencer finishes one command (execute, head re-read, age multiply,
//   emit) around the single slot memory before it takes the next one.
// Reset (synchronous, active low) clears all control and statistics; slot memory is not cleared.
// Depends on rtq_pkg, rtq_if, rtq_front, rtq_fifo, rtq_back.
module retransmit_outbox_queue_core import rtq_pkg::*; #(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    rtq_item_if.sink     i_cmd_ch,
    rtq_result_if.source o_res_ch
);
    // Front classifies each item and pushes it into the queue; the back
    // drains the queue one command at a time, so an incoming item can be
    // taken while a finished result still waits in the output register.
    logic    s_push;
    logic    s_pop;
    t_work   s_work_in;
    t_work   s_work_out;
    t_q_stat s_stat;

    rtq_front u_front (
        .i_cmd_ch (i_cmd_ch),
        .i_stat   (s_stat),
        .o_push   (s_push),
        .o_work   (s_work_in)
    );

    // Hold up to two classified commands between the halves.
    rtq_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_push),
        .i_wdata (s_work_in),
        .i_pop   (s_pop),
        .o_rdata (s_work_out),
        .o_stat  (s_stat)
    );

    // Execute against the ring, the timers and the drop statistics.
    rtq_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_stat      (s_stat),
        .i_work      (s_work_out),
        .o_pop       (s_pop),
        .o_res_ch    (o_res_ch)
    );
endmodule

[test/rtq_outbox_checker.sv]
// Checker for the retransmit outbox queue: tracks accepted commands, predicts each result
// and compares it field by field. Depends on rtq_pkg and rtq_if.
module rtq_outbox_checker import rtq_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    rtq_item_if.sink    i_cmd_mon,
    rtq_result_if.sink  i_res_mon,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    t_slot       ring [DEF_CAPACITY];
    logic [3:0]  head_idx;
    logic [4:0]  held;
    logic [31:0] sent_at;
    logic [31:0] drops;
    logic        drop_kind;
    logic [31:0] drop_seq;
    logic        sent_flag;
    logic        due_flag;
    logic [31:0] timeout_ms;
    t_result     expected_q [$];

    function automatic logic ieee_same(logic [31:0] x, logic [31:0] y);
        logic xn;
        logic yn;
        xn = (x[30:23] == 8'hFF) && (x[22:0] != 0);
        yn = (y[30:23] == 8'hFF) && (y[22:0] != 0);
        if (xn || yn) return 1'b0;
        if (x[30:0] == 0 && y[30:0] == 0) return 1'b1;
        return x == y;
    endfunction

    task automatic drop_head();
        head_idx  = head_idx + 4'd1;
        held      = held - 5'd1;
        sent_flag = 1'b0;
        due_flag  = held != 0;
    endtask

    task automatic push_record(logic kind, logic flag, t_item it);
        logic [3:0] tail;
        if (held == DEF_CAPACITY) begin
            drop_kind = ring[head_idx].kind;
            drop_seq  = ring[head_idx].seq;
            drops     = drops + 32'd1;
            drop_head();
        end
        tail = head_idx + held[3:0];
        ring[tail] = '{kind: kind, flag: flag, seq: it.sequence_req,
                       time_ms: it.captured_at_ms, ab: {it.payload_b, it.payload_a},
                       c: it.payload_c};
        held = held + 5'd1;
        if (held == 1) begin
            sent_flag = 1'b0;
            due_flag  = 1'b1;
        end
    endtask

    function automatic void reset_runtime();
        head_idx = 0; held = 0; sent_at = 0; drops = 0;
        drop_kind = 0; drop_seq = 0; sent_flag = 0; due_flag = 0;
    endfunction

    task automatic predict_queue(t_item it);
        t_result    r;
        logic       ok;
        logic [3:0] back;
        logic [31:0] age;
        ok = 1'b0;
        case (it.cmd)
            CMD_ENQ_TEMP: if (it.sequence_ok) begin
                push_record(KIND_TEMP, it.payload_flag, it);
                ok = 1'b1;
            end
            CMD_ENQ_BUBBLE: if (it.sequence_ok && it.payload_flag) begin
                push_record(KIND_BUBBLE, 1'b1, it);
                ok = 1'b1;
            end
            CMD_POLL: if (held != 0 && it.link_ready)
                ok = due_flag || (sent_flag && (it.now_ms - sent_at) >= timeout_ms);
            CMD_RECORD_SEND: if (held != 0) begin
                sent_at = it.now_ms; sent_flag = 1'b1; due_flag = 1'b0;
            end
            CMD_LOST: if (held != 0 && sent_flag) due_flag = 1'b1;
            CMD_ACK: if (held != 0 && ring[head_idx].seq == it.sequence_req) begin
                drop_head();
                ok = 1'b1;
            end
            CMD_COMPARE: if (held != 0) begin
                back = head_idx + held[3:0] - 4'd1;
                if (ring[back].kind == KIND_TEMP)
                    ok = ieee_same(ring[back].ab[31:0], it.payload_a)
                      && ieee_same(ring[back].ab[63:32], it.payload_b);
            end
            default: reset_runtime();
        endcase
        r = '0;
        r.ok = ok;
        r.is_retry = sent_flag;
        r.entry_count = held;
        r.dropped_count = drops;
        r.last_dropped_kind = drop_kind;
        r.last_dropped_sequence = drop_seq;
        if (held != 0) begin
            age = (it.now_ms - ring[head_idx].time_ms) / 32'd1000;
            r.head_kind = ring[head_idx].kind;
            r.head_sequence = ring[head_idx].seq;
            r.head_age_seconds = age[22:0];
            r.head_payload_low = ring[head_idx].ab;
            r.head_payload_high = {ring[head_idx].flag, ring[head_idx].c};
        end
        expected_q.push_back(r);
    endtask

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0h actual %0h", name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result w;
        t_result g;
        if (!i_rst_n) begin
            reset_runtime();
            timeout_ms = ACK_TIMEOUT_RESET;
            expected_q.delete();
        end else begin
            if (i_cfg_we) timeout_ms = i_cfg_wdata;
            if (i_res_mon.valid && i_res_mon.ready) begin
                g = i_res_mon.payload;
                if (expected_q.size() == 0) begin
                    $error("result with no expectation waiting");
                    o_fail_count++;
                end else begin
                    w = expected_q.pop_front();
                    check_field("ok", w.ok, g.ok);
                    check_field("is_retry", w.is_retry, g.is_retry);
                    check_field("entry_count", w.entry_count, g.entry_count);
                    check_field("dropped_count", w.dropped_count, g.dropped_count);
                    check_field("last_dropped_kind", w.last_dropped_kind,
                                g.last_dropped_kind);
                    check_field("last_dropped_sequence", w.last_dropped_sequence,
                                g.last_dropped_sequence);
                    check_field("head_kind", w.head_kind, g.head_kind);
                    check_field("head_sequence", w.head_sequence, g.head_sequence);
                    check_field("head_age_seconds", w.head_age_seconds,
                                g.head_age_seconds);
                    check_field("head_payload_low", w.head_payload_low,
                                g.head_payload_low);
                    check_field("head_payload_high", w.head_payload_high,
                                g.head_payload_high);
                end
            end
            if (i_cmd_mon.valid && i_cmd_mon.ready) predict_queue(i_cmd_mon.payload);
        end
        o_pending <= expected_q.size();
    end

    initial begin
        o_fail_count = 0;
        o_pending = 0;
        timeout_ms = ACK_TIMEOUT_RESET;
    end
endmodule

[test/tb_retransmit_outbox_queue_core.sv]
// Testbench top for retransmit_outbox_queue_core: drives commands under random idling,
// writes the ack timeout between phases and reports the verdict.
// Depends on rtq_pkg, rtq_if, the core RTL and rtq_outbox_checker.
module tb_retransmit_outbox_queue_core import rtq_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [31:0] cfg_wdata;
    int          fail_count;
    int          pending;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          hold_off_cycles;
    bit          stim_done;

    rtq_item_if   cmd_ch();
    rtq_result_if res_ch();

    retransmit_outbox_queue_core u_dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata),
        .i_cmd_ch(cmd_ch.sink), .o_res_ch(res_ch.source)
    );

    rtq_outbox_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata),
        .i_cmd_mon(cmd_ch.sink), .i_res_mon(res_ch.sink),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        clk = 1'b1; #6;
        clk = 1'b0; #6;
    end

    // Sequence numbers of recent enqueues, so that acks often hit the head.
    logic [31:0] seq_log [$];
    logic [31:0] now_clock;
    logic [31:0] last_pa;
    logic [31:0] last_pb;

    // Receiver: random stall, or a long hold-off counted here when requested.
    always @(posedge clk) begin
        if (!rst_n) begin
            res_ch.ready <= 1'b0;
        end else if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic logic [31:0] pick_float();
        case ($urandom_range(7))
            0: return 32'h0000_0000;
            1: return 32'h8000_0000;
            2: return 32'h7FC0_0000 | $urandom_range(32'h3F_FFFF);
            3: return 32'h7F80_0000;
            4: return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    function automatic t_item build_item(logic [2:0] cmd);
        t_item it;
        it.cmd = cmd;
        it.sequence_req = $urandom();
        it.sequence_ok = ($urandom_range(9) != 0);
        it.captured_at_ms = now_clock - $urandom_range(60000);
        if ($urandom_range(15) == 0) it.captured_at_ms = $urandom();
        it.payload_a = pick_float();
        it.payload_b = pick_float();
        it.payload_c = $urandom();
        it.payload_flag = ($urandom_range(4) != 0);
        it.link_ready = ($urandom_range(5) != 0);
        it.now_ms = now_clock;
        if (cmd == CMD_ACK && seq_log.size() > 0 && $urandom_range(3) != 0)
            it.sequence_req = seq_log[$urandom_range(seq_log.size() - 1)];
        if (cmd == CMD_COMPARE && $urandom_range(2) != 0) begin
            it.payload_a = last_pa;
            it.payload_b = last_pb;
        end
        return it;
    endfunction

    // Offer one item, hold it until accepted, then advance time as the sender sees it.
    // Valid stays high after acceptance; the next call either replaces the item
    // or drops valid while it idles.
    task automatic send_item(t_item it);
        if ($urandom_range(99) < send_idle_pct) begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge clk);
        end
        cmd_ch.valid   <= 1'b1;
        cmd_ch.payload <= it;
        @(posedge clk);
        while (!cmd_ch.ready) @(posedge clk);
        if ((it.cmd == CMD_ENQ_TEMP || it.cmd == CMD_ENQ_BUBBLE) && it.sequence_ok) begin
            seq_log.push_back(it.sequence_req);
            if (seq_log.size() > 24) void'(seq_log.pop_front());
            if (it.cmd == CMD_ENQ_TEMP) begin
                last_pa = it.payload_a;
                last_pb = it.payload_b;
            end
        end
        now_clock = now_clock + $urandom_range(4000);
    endtask

    task automatic drain_results();
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic write_timeout(logic [31:0] value);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Weighted command mix: well-formed enqueue/poll/send/ack flows dominate.
    function automatic logic [2:0] pick_cmd();
        int r;
        r = $urandom_range(99);
        if (r < 30) return CMD_ENQ_TEMP;
        if (r < 42) return CMD_ENQ_BUBBLE;
        if (r < 56) return CMD_POLL;
        if (r < 66) return CMD_RECORD_SEND;
        if (r < 72) return CMD_LOST;
        if (r < 88) return CMD_ACK;
        if (r < 97) return CMD_COMPARE;
        return CMD_CLEAR;
    endfunction

    task automatic run_random(int n);
        for (int k = 0; k < n; k++) send_item(build_item(pick_cmd()));
    endtask

    initial begin
        t_item it;
        cmd_ch.valid   = 1'b0;
        cmd_ch.payload = '0;
        res_ch.ready   = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        rst_n = 1'b0;
        hold_off_cycles = 0;
        stim_done = 1'b0;
        send_idle_pct = 38;
        recv_idle_pct = 56;
        now_clock = 32'hFFFF_0000;
        last_pa = 0;
        last_pb = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty-ring commands, rejects, extremes, wrap, IEEE compare.
        for (int c = CMD_POLL; c <= CMD_CLEAR; c++) send_item(build_item(c[2:0]));
        it = build_item(CMD_ENQ_TEMP); it.sequence_ok = 1'b0; send_item(it);
        it = build_item(CMD_ENQ_BUBBLE); it.payload_flag = 1'b0; send_item(it);
        it = build_item(CMD_ENQ_TEMP);
        it.sequence_ok = 1'b1; it.sequence_req = '1; it.captured_at_ms = '1;
        it.payload_a = 32'h8000_0000; it.payload_b = 32'h7FC0_0000;
        it.payload_c = '1; it.payload_flag = 1'b1; send_item(it);
        it = build_item(CMD_COMPARE); it.payload_a = 0; it.payload_b = 32'h7FC0_0000;
        send_item(it);
        it = build_item(CMD_POLL); it.link_ready = 1'b1; send_item(it);
        it = build_item(CMD_RECORD_SEND); it.now_ms = '1; send_item(it);
        it = build_item(CMD_LOST); send_item(it);
        it = build_item(CMD_POLL); it.link_ready = 1'b1; it.now_ms = 0; send_item(it);
        it = build_item(CMD_ENQ_BUBBLE);
        it.sequence_ok = 1'b1; it.payload_flag = 1'b1; it.sequence_req = 0;
        it.captured_at_ms = 0; it.payload_a = 0; it.payload_b = '1; send_item(it);
        for (int k = 0; k < 17; k++) begin
            it = build_item(CMD_ENQ_TEMP); it.sequence_ok = 1'b1; send_item(it);
        end
        it = build_item(CMD_CLEAR); send_item(it);

        write_timeout(32'd0);
        run_random(250);
        // Receiver holds off while the sender keeps offering, filling the block.
        write_timeout(32'hFFFF_FFFF);
        hold_off_cycles <= 300;
        run_random(60);
        drain_results();
        send_idle_pct = 56;
        recv_idle_pct = 38;
        write_timeout(32'd3000);
        run_random(300);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_timeout(32'd20000);
        run_random(300);
        drain_results();
        repeat (30) @(posedge clk);
        stim_done = 1'b1;
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #50ms;
        $display("CHECKS FAILED");
        $finish;
    end

    final begin
        if (pending != 0 && stim_done) $error("expectations left over: %0d", pending);
    end
endmodule

[files.f]
hdl/rtq_pkg.sv
hdl/rtq_if.sv
hdl/rtq_fifo.sv
hdl/rtq_front.sv
hdl/rtq_back.sv
hdl/retransmit_outbox_queue_core.sv
test/rtq_outbox_checker.sv
test/tb_retransmit_outbox_queue_core.sv
